[rtl/mchw_pkg.sv]
package mchw_pkg;

   localparam int unsigned NUM_CHANNELS_DEFAULT = 8;
   localparam int unsigned QUEUE_DEPTH_DEFAULT  = 4;

   localparam int unsigned MASK_W      = 8;
   localparam int unsigned UPTIME_W    = 32;
   localparam int unsigned TIMER_W     = 24;
   localparam int unsigned CHANNEL_W   = 3;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam int unsigned TIMEOUT_TICKS = 60 * 1000;

   localparam logic [TIMER_W-1:0] WAIT_MAX_RESET       = TIMER_W'(TIMEOUT_TICKS);
   localparam logic [TIMER_W-1:0] EVAL_PERIOD_RESET    = TIMER_W'(TIMEOUT_TICKS / 2);
   localparam logic [MASK_W-1:0]  CHANNEL_ENABLE_RESET = 8'd31;
   localparam logic [MASK_W-1:0]  MONITOR_MASK_RESET   = 8'd1;
   localparam logic               ALLOW_RESTART_RESET  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAIT_MAX       = 3'd0,
      CSR_EVAL_PERIOD    = 3'd1,
      CSR_CHANNEL_ENABLE = 3'd2,
      CSR_MONITOR_MASK   = 3'd3,
      CSR_ALLOW_RESTART  = 3'd4
   } csr_index_type;

   localparam logic OPCODE_TICK = 1'b0;
   localparam logic OPCODE_DONE = 1'b1;

   localparam logic [1:0] GRADE_COMPLETE = 2'd0;
   localparam logic [1:0] GRADE_WAITING  = 2'd1;
   localparam logic [1:0] GRADE_HALF     = 2'd2;
   localparam logic [1:0] GRADE_OVERDUE  = 2'd3;

   localparam logic [1:0] ACTION_NONE    = 2'd0;
   localparam logic [1:0] ACTION_DUMP    = 2'd1;
   localparam logic [1:0] ACTION_HUNG    = 2'd2;
   localparam logic [1:0] ACTION_RESTART = 2'd3;

   // Work handed from the front to the back.
   typedef enum logic [1:0] {
      KIND_DONE = 2'd0,
      KIND_ARM  = 2'd1,
      KIND_EVAL = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [CHANNEL_W-1:0]   channel;
      logic [MASK_W-1:0]      idle_mask;
      logic [UPTIME_W-1:0]    uptime;
   } work_type;

   typedef struct packed {
      logic [TIMER_W-1:0] wait_max;
      logic [MASK_W-1:0]  channel_enable;
      logic [MASK_W-1:0]  monitor_mask;
      logic               allow_restart;
   } back_cfg_type;

endpackage

[rtl/mchw_front.sv]
module mchw_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [mchw_pkg::CHANNEL_W-1:0]     req_channel,
   input  logic [mchw_pkg::MASK_W-1:0]        req_idle_mask,
   input  logic [mchw_pkg::TIMER_W-1:0]       eval_period,
   output logic                               push_valid,
   input  logic                               push_ready,
   output mchw_pkg::work_type                 push_work
);

   logic [mchw_pkg::UPTIME_W-1:0] uptime_ff, uptime_in, uptime_inc;
   logic [mchw_pkg::TIMER_W-1:0]  interval_ff, interval_in, interval_inc;
   logic                          arm_pending_ff, arm_pending_in;
   logic                          accept;

   assign req_ready    = push_ready;
   assign accept       = req_valid && req_ready;
   assign uptime_inc   = uptime_ff + 1'b1;
   assign interval_inc = interval_ff + 1'b1;

   always_comb begin
      uptime_in           = uptime_ff;
      interval_in         = interval_ff;
      arm_pending_in      = arm_pending_ff;
      push_valid          = 1'b0;
      push_work.kind      = mchw_pkg::KIND_DONE;
      push_work.channel   = req_channel;
      push_work.idle_mask = req_idle_mask;
      push_work.uptime    = uptime_inc;
      if (accept) begin
         if (req_opcode == mchw_pkg::OPCODE_DONE) begin
            push_valid = 1'b1;
         end else begin
            uptime_in = uptime_inc;
            if (arm_pending_ff) begin
               push_valid     = 1'b1;
               push_work.kind = mchw_pkg::KIND_ARM;
               arm_pending_in = 1'b0;
               interval_in    = '0;
            end else if (interval_inc >= eval_period) begin
               push_valid     = 1'b1;
               push_work.kind = mchw_pkg::KIND_EVAL;
               interval_in    = '0;
            end else begin
               interval_in = interval_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uptime_ff      <= '0;
         interval_ff    <= '0;
         arm_pending_ff <= 1'b1;
      end else begin
         uptime_ff      <= uptime_in;
         interval_ff    <= interval_in;
         arm_pending_ff <= arm_pending_in;
      end
   end

endmodule

[rtl/mchw_queue.sv]
module mchw_queue #(
   parameter int unsigned DEPTH = mchw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mchw_pkg::work_type  push_work,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mchw_pkg::work_type  pop_work
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   mchw_pkg::work_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_work   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

[rtl/mchw_back.sv]
module mchw_back #(
   parameter int unsigned NUM_CHANNELS = mchw_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mchw_pkg::back_cfg_type         cfg,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  mchw_pkg::work_type             pop_work,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_severity,
   output logic [1:0]                     rsp_action,
   output logic [mchw_pkg::MASK_W-1:0]    rsp_blocked_mask,
   output logic [mchw_pkg::MASK_W-1:0]    rsp_posted_mask,
   output logic                           rsp_fresh_trace
);

   logic [NUM_CHANNELS-1:0] lane_wait, lane_half, lane_over, lane_blocked, lane_posted;
   logic [mchw_pkg::MASK_W-1:0] blocked8, posted8;
   logic [mchw_pkg::UPTIME_W-1:0] wmax32, half32;
   logic out_free, exec, is_done, is_arm, is_eval;
   logic any_wait, any_half, any_over;
   logic [1:0] severity, action;
   logic half_reported_ff, half_reported_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] severity_ff, action_ff;
   logic [mchw_pkg::MASK_W-1:0] blocked_ff, posted_ff;
   logic fresh_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (pop_work.kind != mchw_pkg::KIND_EVAL) || out_free;
   assign exec      = pop_valid && pop_ready;
   assign is_done   = exec && (pop_work.kind == mchw_pkg::KIND_DONE);
   assign is_eval   = exec && (pop_work.kind == mchw_pkg::KIND_EVAL);
   assign is_arm    = is_eval || (exec && (pop_work.kind == mchw_pkg::KIND_ARM));

   assign wmax32 = {{(mchw_pkg::UPTIME_W - mchw_pkg::TIMER_W){1'b0}}, cfg.wait_max};
   assign half32 = {{(mchw_pkg::UPTIME_W - mchw_pkg::TIMER_W + 1){1'b0}},
                    cfg.wait_max[mchw_pkg::TIMER_W-1:1]};

   // One lane per channel: its completion flag, start time and grade.
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      logic done_ff, done_in;
      logic [mchw_pkg::UPTIME_W-1:0] start_ff, start_in, latency;
      logic en, mon, idle, match, pending, shortcut;

      if (g < mchw_pkg::MASK_W) begin : g_watched
         assign en    = cfg.channel_enable[g];
         assign mon   = cfg.monitor_mask[g];
         assign idle  = pop_work.idle_mask[g];
         assign match = (pop_work.channel == mchw_pkg::CHANNEL_W'(g));
      end else begin : g_unwatched
         assign en    = 1'b0;
         assign mon   = 1'b0;
         assign idle  = 1'b0;
         assign match = 1'b0;
      end

      assign latency  = pop_work.uptime - start_ff;
      assign pending  = en && !done_ff;
      assign shortcut = !mon && idle;

      assign lane_wait[g]    = pending && (latency < half32);
      assign lane_half[g]    = pending && !(latency < half32) && (latency < wmax32);
      assign lane_over[g]    = pending && !(latency < wmax32);
      assign lane_blocked[g] = pending && (latency > wmax32);
      assign lane_posted[g]  = is_arm && en && !shortcut && done_ff;

      always_comb begin
         done_in  = done_ff;
         start_in = start_ff;
         if (is_done && match) begin
            done_in = 1'b1;
         end else if (is_arm && en) begin
            if (shortcut) begin
               done_in = 1'b1;
            end else if (done_ff) begin
               done_in  = 1'b0;
               start_in = pop_work.uptime;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b1;
         end else begin
            done_ff <= done_in;
         end
      end

      // The start time is only read while the channel is pending, after arming wrote it.
      always_ff @(posedge clock) begin
         start_ff <= start_in;
      end
   end

   for (genvar b = 0; b < mchw_pkg::MASK_W; b++) begin : g_mask
      if (b < NUM_CHANNELS) begin : g_used
         assign blocked8[b] = lane_blocked[b];
         assign posted8[b]  = lane_posted[b];
      end else begin : g_absent
         assign blocked8[b] = 1'b0;
         assign posted8[b]  = 1'b0;
      end
   end

   assign any_wait = |lane_wait;
   assign any_half = |lane_half;
   assign any_over = |lane_over;

   always_comb begin
      if (any_over) begin
         severity = mchw_pkg::GRADE_OVERDUE;
      end else if (any_half) begin
         severity = mchw_pkg::GRADE_HALF;
      end else if (any_wait) begin
         severity = mchw_pkg::GRADE_WAITING;
      end else begin
         severity = mchw_pkg::GRADE_COMPLETE;
      end
   end

   always_comb begin
      action           = mchw_pkg::ACTION_NONE;
      half_reported_in = half_reported_ff;
      case (severity)
         mchw_pkg::GRADE_COMPLETE: begin
            half_reported_in = 1'b0;
         end
         mchw_pkg::GRADE_HALF: begin
            if (!half_reported_ff) begin
               action           = mchw_pkg::ACTION_DUMP;
               half_reported_in = 1'b1;
            end
         end
         mchw_pkg::GRADE_OVERDUE: begin
            action           = cfg.allow_restart ? mchw_pkg::ACTION_RESTART
                                                 : mchw_pkg::ACTION_HUNG;
            half_reported_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (is_eval) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         half_reported_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (is_eval) begin
            half_reported_ff <= half_reported_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_eval) begin
         severity_ff <= severity;
         action_ff   <= action;
         blocked_ff  <= any_over ? blocked8 : '0;
         posted_ff   <= posted8;
         fresh_ff    <= any_over && !half_reported_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_severity     = severity_ff;
   assign rsp_action       = action_ff;
   assign rsp_blocked_mask = blocked_ff;
   assign rsp_posted_mask  = posted_ff;
   assign rsp_fresh_trace  = fresh_ff;

`ifndef ASSERT_OFF
   a_overdue_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_severity != mchw_pkg::GRADE_OVERDUE) |->
         (rsp_blocked_mask == '0) && !rsp_fresh_trace)
      else $error("blocked mask or fresh trace set below overdue");

   a_dump_on_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == mchw_pkg::ACTION_DUMP) |->
         (rsp_severity == mchw_pkg::GRADE_HALF))
      else $error("stack dump requested without half-way grade");

   a_eval_delivers: assert property (@(posedge clock) disable iff (reset)
      is_eval |=> rsp_valid)
      else $error("evaluation did not reach the response register");
`endif

endmodule

[rtl/multi_channel_hang_watchdog_unit.sv]
// Multi-channel hang watchdog.
//
// Requests arrive on the req_ channel (valid/ready). A tick request (opcode 0)
// advances the uptime counter and carries the idle mask of the channels; a
// done request (opcode 1) marks the check of req_channel as complete. Once per
// evaluation period of ticks the watched channels are graded and one response
// goes out on the rsp_ channel (valid/ready); all other requests produce
// nothing. Registers are written on the csr_ channel, which is always ready.
//
// Throughput is one request per cycle while req_ready is high. The front
// keeps the time base and decides what each request does; a small queue feeds
// the back, which grades all channels in parallel lanes. With an empty queue,
// an evaluating tick is written into the queue, then graded into the response
// register, where rsp_valid rises. When the receiver stalls, the response
// holds in its output register, queued work ahead of the next evaluating tick
// still drains, and that tick then waits at the head of the queue with all
// work behind it; quiet ticks are still taken until the queue is full, and
// then req_ready drops. After reset all channels count as complete, the
// registers take their defaults, and the first tick only arms the channels.
module multi_channel_hang_watchdog_unit #(
   parameter int unsigned NUM_CHANNELS = mchw_pkg::NUM_CHANNELS_DEFAULT,
   parameter int unsigned QUEUE_DEPTH  = mchw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [mchw_pkg::CHANNEL_W-1:0]     req_channel,
   input  logic [mchw_pkg::MASK_W-1:0]        req_idle_mask,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_severity,
   output logic [1:0]                         rsp_action,
   output logic [mchw_pkg::MASK_W-1:0]        rsp_blocked_mask,
   output logic [mchw_pkg::MASK_W-1:0]        rsp_posted_mask,
   output logic                               rsp_fresh_trace,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mchw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mchw_pkg::TIMER_W-1:0]       csr_wdata
);

   logic [mchw_pkg::TIMER_W-1:0] wait_max_ff, eval_period_ff;
   logic [mchw_pkg::MASK_W-1:0]  channel_enable_ff, monitor_mask_ff;
   logic                         allow_restart_ff;
   logic                         csr_write;

   mchw_pkg::back_cfg_type back_cfg;
   mchw_pkg::work_type     push_work, pop_work;
   logic push_valid, push_ready, pop_valid, pop_ready;

   // Register writes take effect at once; indexes beyond the list are ignored.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_max_ff       <= mchw_pkg::WAIT_MAX_RESET;
         eval_period_ff    <= mchw_pkg::EVAL_PERIOD_RESET;
         channel_enable_ff <= mchw_pkg::CHANNEL_ENABLE_RESET;
         monitor_mask_ff   <= mchw_pkg::MONITOR_MASK_RESET;
         allow_restart_ff  <= mchw_pkg::ALLOW_RESTART_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mchw_pkg::CSR_WAIT_MAX:       wait_max_ff       <= csr_wdata;
            mchw_pkg::CSR_EVAL_PERIOD:    eval_period_ff    <= csr_wdata;
            mchw_pkg::CSR_CHANNEL_ENABLE: channel_enable_ff <= csr_wdata[mchw_pkg::MASK_W-1:0];
            mchw_pkg::CSR_MONITOR_MASK:   monitor_mask_ff   <= csr_wdata[mchw_pkg::MASK_W-1:0];
            mchw_pkg::CSR_ALLOW_RESTART:  allow_restart_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign back_cfg.wait_max       = wait_max_ff;
   assign back_cfg.channel_enable = channel_enable_ff;
   assign back_cfg.monitor_mask   = monitor_mask_ff;
   assign back_cfg.allow_restart  = allow_restart_ff;

   // Front: time base, interval counter and request classification.
   mchw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_channel    (req_channel),
      .req_idle_mask  (req_idle_mask),
      .eval_period    (eval_period_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_work      (push_work)
   );

   // Queue that decouples the front from a stalled back.
   mchw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_work   (pop_work)
   );

   // Back: per-channel state, grading, arming and the response register.
   mchw_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (back_cfg),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_work         (pop_work),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_severity     (rsp_severity),
      .rsp_action       (rsp_action),
      .rsp_blocked_mask (rsp_blocked_mask),
      .rsp_posted_mask  (rsp_posted_mask),
      .rsp_fresh_trace  (rsp_fresh_trace)
   );

endmodule

[test/tb_multi_channel_hang_watchdog_unit.sv]
`timescale 1ns / 1ps

module tb_multi_channel_hang_watchdog_unit;

   typedef logic [mchw_pkg::TIMER_W-1:0]     timer_type;
   typedef logic [mchw_pkg::MASK_W-1:0]      mask_type;
   typedef logic [mchw_pkg::CHANNEL_W-1:0]   channel_type;
   typedef logic [mchw_pkg::CSR_INDEX_W-1:0] index_type;
   typedef logic [mchw_pkg::UPTIME_W-1:0]    uptime_type;

   // Cycles that are allowed to pass with no handshake on any channel before
   // the run is declared hung.
   localparam int unsigned STALL_LIMIT   = 2000;
   // Quiet cycles after the last response, so that done and arming work still
   // in the front queue has drained before a register is touched.
   localparam int unsigned SETTLE_CYCLES = mchw_pkg::QUEUE_DEPTH_DEFAULT + 8;
   // An index that has no register behind it; writes to it must be ignored.
   localparam index_type CSR_UNUSED_INDEX = 3'd7;
   // Short evaluation period for the opening check of the other reset values.
   localparam timer_type OPENING_PERIOD = 24'd40;

   typedef enum int {
      PACE_STEADY,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH_IDLE
   } pace_mode_type;

   typedef struct packed {
      logic        opcode;
      channel_type channel;
      mask_type    idle_mask;
   } watch_request_type;

   typedef struct packed {
      logic [1:0] severity;
      logic [1:0] action;
      mask_type   blocked_mask;
      mask_type   posted_mask;
      logic       fresh_trace;
   } hang_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_opcode    = mchw_pkg::OPCODE_TICK;
   channel_type req_channel   = '0;
   mask_type    req_idle_mask = '0;

   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [1:0]  rsp_severity;
   logic [1:0]  rsp_action;
   mask_type    rsp_blocked_mask;
   mask_type    rsp_posted_mask;
   logic        rsp_fresh_trace;

   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   index_type   csr_index     = '0;
   timer_type   csr_wdata     = '0;

   multi_channel_hang_watchdog_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_channel      (req_channel),
      .req_idle_mask    (req_idle_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_severity     (rsp_severity),
      .rsp_action       (rsp_action),
      .rsp_blocked_mask (rsp_blocked_mask),
      .rsp_posted_mask  (rsp_posted_mask),
      .rsp_fresh_trace  (rsp_fresh_trace),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Requests waiting to be driven, and the reports that the accepted requests
   // are predicted to produce, oldest first.
   watch_request_type queued_requests[$];
   hang_report_type   awaited_reports[$];

   // Handshakes seen at the last rising edge, read by the falling-edge drivers.
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   int unsigned failures        = 0;
   int unsigned ticks_accepted  = 0;
   int unsigned dones_accepted  = 0;
   int unsigned reports_checked = 0;
   int unsigned overdue_reports = 0;
   int unsigned half_reports    = 0;
   int unsigned settings_used   = 0;
   int unsigned idle_cycles     = 0;

   // ------------------------------------------------------------------------
   // Predictor of the watchdog. It keeps its own copy of the registers and of
   // the per-channel state, and is stepped once per accepted request.
   // ------------------------------------------------------------------------
   timer_type  cfg_wait_max;
   timer_type  cfg_eval_period;
   mask_type   cfg_channel_enable;
   mask_type   cfg_monitor_mask;
   logic       cfg_allow_restart;

   uptime_type model_uptime;
   timer_type  model_interval;
   mask_type   model_done;
   uptime_type model_start [mchw_pkg::MASK_W];
   logic       model_half_reported;
   logic       model_arm_pending;

   function automatic void reset_watchdog_model();
      cfg_wait_max        = mchw_pkg::WAIT_MAX_RESET;
      cfg_eval_period     = mchw_pkg::EVAL_PERIOD_RESET;
      cfg_channel_enable  = mchw_pkg::CHANNEL_ENABLE_RESET;
      cfg_monitor_mask    = mchw_pkg::MONITOR_MASK_RESET;
      cfg_allow_restart   = mchw_pkg::ALLOW_RESTART_RESET;
      model_uptime        = '0;
      model_interval      = '0;
      model_done          = '1;
      model_half_reported = 1'b0;
      model_arm_pending   = 1'b1;
      for (int i = 0; i < mchw_pkg::MASK_W; i++) begin
         model_start[i] = '0;
      end
   endfunction

   function automatic void apply_register(index_type index, timer_type data);
      case (index)
         mchw_pkg::CSR_WAIT_MAX:       cfg_wait_max       = data;
         mchw_pkg::CSR_EVAL_PERIOD:    cfg_eval_period    = data;
         mchw_pkg::CSR_CHANNEL_ENABLE: cfg_channel_enable = data[mchw_pkg::MASK_W-1:0];
         mchw_pkg::CSR_MONITOR_MASK:   cfg_monitor_mask   = data[mchw_pkg::MASK_W-1:0];
         mchw_pkg::CSR_ALLOW_RESTART:  cfg_allow_restart  = data[0];
         default: ;
      endcase
   endfunction

   // Re-arms the watched channels. An idle channel without a monitor counts as
   // complete; a channel still pending keeps its start time; every other one
   // starts a new check now and is reported as posted.
   function automatic mask_type rearm_channels(mask_type idle);
      mask_type posted;
      posted = '0;
      for (int i = 0; i < mchw_pkg::MASK_W; i++) begin
         if (!cfg_channel_enable[i]) continue;
         if (!cfg_monitor_mask[i] && idle[i]) begin
            model_done[i] = 1'b1;
            continue;
         end
         if (!model_done[i]) continue;
         model_done[i]  = 1'b0;
         model_start[i] = model_uptime;
         posted[i]      = 1'b1;
      end
      return posted;
   endfunction

   // Returns 1 when the request is an evaluating tick, with its report.
   function automatic bit predict_report(watch_request_type rq,
                                         output hang_report_type rep);
      logic [1:0] worst;
      logic [1:0] grade;
      mask_type   blocked;
      uptime_type latency;
      uptime_type wait_limit;
      rep = '0;
      if (rq.opcode == mchw_pkg::OPCODE_DONE) begin
         model_done[rq.channel] = 1'b1;
         return 1'b0;
      end
      model_uptime = model_uptime + 1'b1;
      if (model_arm_pending) begin
         void'(rearm_channels(rq.idle_mask));
         model_arm_pending = 1'b0;
         model_interval    = '0;
         return 1'b0;
      end
      model_interval = model_interval + 1'b1;
      if (model_interval < cfg_eval_period) return 1'b0;

      // Grade every watched channel that is still pending. The uptime difference is
      // taken modulo 2^32, exactly like the uptime counter.
      wait_limit = {8'd0, cfg_wait_max};
      worst      = mchw_pkg::GRADE_COMPLETE;
      blocked    = '0;
      for (int i = 0; i < mchw_pkg::MASK_W; i++) begin
         if (!cfg_channel_enable[i] || model_done[i]) continue;
         latency = model_uptime - model_start[i];
         if (latency < (wait_limit >> 1)) grade = mchw_pkg::GRADE_WAITING;
         else if (latency < wait_limit) grade = mchw_pkg::GRADE_HALF;
         else grade = mchw_pkg::GRADE_OVERDUE;
         if (grade > worst) worst = grade;
         if (latency > wait_limit) blocked[i] = 1'b1;
      end

      rep.severity = worst;
      rep.action   = mchw_pkg::ACTION_NONE;
      case (worst)
         mchw_pkg::GRADE_COMPLETE: model_half_reported = 1'b0;
         mchw_pkg::GRADE_HALF: begin
            if (!model_half_reported) begin
               rep.action          = mchw_pkg::ACTION_DUMP;
               model_half_reported = 1'b1;
            end
         end
         mchw_pkg::GRADE_OVERDUE: begin
            rep.fresh_trace     = !model_half_reported;
            rep.action          = cfg_allow_restart ? mchw_pkg::ACTION_RESTART
                                                    : mchw_pkg::ACTION_HUNG;
            rep.blocked_mask    = blocked;
            model_half_reported = 1'b0;
         end
         default: ;
      endcase
      rep.posted_mask = rearm_channels(rq.idle_mask);
      model_interval  = '0;
      return 1'b1;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver. Inputs change on the falling edge only. A request stays
   // on the port until the rising edge that accepts it; after that the next
   // one may follow at once or after a random gap, depending on the pace.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      watch_request_type next_req;
      if (!req_valid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req      = queued_requests.pop_front();
            req_valid     <= 1'b1;
            req_opcode    <= next_req.opcode;
            req_channel   <= next_req.channel;
            req_idle_mask <= next_req.idle_mask;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor. On every rising edge it applies accepted register writes to the
   // predictor, steps the predictor with each accepted request, and compares
   // each accepted response against the oldest predicted report.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      watch_request_type seen_req;
      hang_report_type   predicted;
      hang_report_type   want;
      if (reset) begin
         reset_watchdog_model();
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         csr_taken <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            seen_req = '{opcode: req_opcode, channel: req_channel,
                         idle_mask: req_idle_mask};
            if (req_opcode == mchw_pkg::OPCODE_TICK) ticks_accepted++;
            else dones_accepted++;
            if (predict_report(seen_req, predicted)) begin
               awaited_reports.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_reports.size() == 0) begin
               $error("response with no report awaited: severity %0d action %0d",
                      rsp_severity, rsp_action);
               failures++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("severity", want.severity, rsp_severity);
               check_field("action", want.action, rsp_action);
               check_field("blocked_mask", want.blocked_mask, rsp_blocked_mask);
               check_field("posted_mask", want.posted_mask, rsp_posted_mask);
               check_field("fresh_trace", want.fresh_trace, rsp_fresh_trace);
               reports_checked++;
               if (want.severity == mchw_pkg::GRADE_OVERDUE) overdue_reports++;
               if (want.severity == mchw_pkg::GRADE_HALF) half_reports++;
            end
         end
      end
   end

   // Hang detector for the testbench itself: any handshake restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic push_request(logic opcode, channel_type channel, mask_type idle);
      queued_requests.push_back('{opcode: opcode, channel: channel, idle_mask: idle});
   endtask

   // Mostly ticks; done requests at the given percentage. Idle masks lean on
   // all-clear and all-set now and then, since those decide the idle shortcut.
   function automatic watch_request_type random_request(int unsigned done_pct);
      watch_request_type rq;
      int unsigned       pick;
      rq.opcode  = ($urandom_range(99) < done_pct) ? mchw_pkg::OPCODE_DONE
                                                   : mchw_pkg::OPCODE_TICK;
      rq.channel = channel_type'($urandom_range(mchw_pkg::MASK_W - 1));
      pick       = $urandom_range(7);
      if (pick == 0) rq.idle_mask = '0;
      else if (pick == 1) rq.idle_mask = '1;
      else rq.idle_mask = mask_type'($urandom_range(255));
      return rq;
   endfunction

   // Waits until nothing is queued, on the port or awaited, then lets the
   // front queue drain of requests that produce no response.
   task automatic wait_for_drain();
      while (queued_requests.size() != 0 || req_valid || awaited_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Must be entered right after a falling edge; returns right after the
   // falling edge that follows acceptance, with csr_valid still high.
   task automatic csr_write(index_type index, timer_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
   endtask

   task automatic configure(timer_type wait_max, timer_type interval,
                            mask_type enable, mask_type monitors, logic restart);
      @(negedge clock);
      csr_write(mchw_pkg::CSR_WAIT_MAX, wait_max);
      csr_write(mchw_pkg::CSR_EVAL_PERIOD, interval);
      csr_write(mchw_pkg::CSR_CHANNEL_ENABLE, {16'd0, enable});
      csr_write(mchw_pkg::CSR_MONITOR_MASK, {16'd0, monitors});
      csr_write(mchw_pkg::CSR_ALLOW_RESTART, {23'd0, restart});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic set_pace(pace_mode_type pace);
      case (pace)
         PACE_SENDER_IDLE:    begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
         PACE_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
         PACE_BOTH_IDLE:      begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         default:             begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // One random phase under one register setting. With hold_midway set the
   // sender stops halfway until every awaited report has come back.
   task automatic run_phase(timer_type wait_max, timer_type interval,
                            mask_type enable, mask_type monitors,
                            logic restart, int unsigned count, pace_mode_type pace,
                            int unsigned done_pct, bit hold_midway);
      configure(wait_max, interval, enable, monitors, restart);
      set_pace(pace);
      for (int unsigned n = 0; n < count; n++) begin
         if (hold_midway && n == count / 2) wait_for_drain();
         queued_requests.push_back(random_request(done_pct));
      end
      wait_for_drain();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults except for a short evaluation period: the first tick
      // only arms the channels. A done request for a pending channel and one
      // for an unwatched channel follow, and the ticks after them bring one
      // report under the default timeout, enables and monitors.
      set_pace(PACE_STEADY);
      csr_write(mchw_pkg::CSR_EVAL_PERIOD, OPENING_PERIOD);
      csr_valid <= 1'b0;
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h0A);
      push_request(mchw_pkg::OPCODE_DONE, 3'd2, 8'h00);
      push_request(mchw_pkg::OPCODE_DONE, 3'd6, 8'hFF);
      for (int n = 0; n < OPENING_PERIOD + 5; n++) begin
         queued_requests.push_back(random_request(0));
      end
      wait_for_drain();

      // Short evaluation period: latency climbs through waiting, past half,
      // exactly equal to the timeout (overdue but not blocked) and beyond.
      // Later, idle unmonitored channels take the shortcut and a done request
      // hits a channel that is not pending. The unused index is written too.
      configure(24'd6, 24'd2, 8'hFF, 8'h0F, 1'b0);
      @(negedge clock);
      csr_write(CSR_UNUSED_INDEX, 24'hA5A5A5);
      csr_valid <= 1'b0;
      push_request(mchw_pkg::OPCODE_DONE, 3'd0, 8'h00);
      push_request(mchw_pkg::OPCODE_DONE, 3'd7, 8'hFF);
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h00);
      push_request(mchw_pkg::OPCODE_TICK, 3'd7, 8'h00);
      for (int n = 0; n < 8; n++) push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h00);
      push_request(mchw_pkg::OPCODE_DONE, 3'd3, 8'h00);
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'hFF);
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'hF0);
      push_request(mchw_pkg::OPCODE_DONE, 3'd5, 8'h00);
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h00);
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h00);
      wait_for_drain();

      // Zero timeout and zero interval: every tick evaluates and every pending
      // channel is overdue; restart requests must not stop the block.
      configure(24'd0, 24'd0, 8'h81, 8'h00, 1'b1);
      for (int n = 0; n < 4; n++) push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h00);
      push_request(mchw_pkg::OPCODE_DONE, 3'd0, 8'h00);
      push_request(mchw_pkg::OPCODE_TICK, 3'd0, 8'h01);
      wait_for_drain();

      // Random phases over fixed settings that include the extremes, with
      // every pacing mode represented.
      run_phase(24'd20, 24'd5, 8'hFF, 8'h0F, 1'b1, 300, PACE_STEADY, 25, 1'b0);
      run_phase(24'd10, 24'd3, 8'hA5, 8'h00, 1'b0, 300, PACE_SENDER_IDLE, 15, 1'b1);
      run_phase(24'hFFFFFF, 24'd1, 8'hFF, 8'hFF, 1'b1, 200, PACE_RECEIVER_STALL, 40,
                1'b0);
      run_phase(24'd7, 24'hFFFFFF, 8'h5A, 8'h00, 1'b0, 100, PACE_BOTH_IDLE, 30, 1'b0);
      run_phase(24'd3, 24'd2, 8'h00, 8'hFF, 1'b0, 60, PACE_STEADY, 20, 1'b0);

      // Random phases over random settings, cycling through the pacing modes.
      for (int k = 0; k < 6; k++) begin
         run_phase(timer_type'($urandom_range(1, 40)), timer_type'($urandom_range(1, 8)),
                   mask_type'($urandom_range(255)), mask_type'($urandom_range(255)),
                   1'($urandom_range(1)), 180, pace_mode_type'(k % 4),
                   $urandom_range(5, 50), 1'b0);
      end

      $display("summary: %0d ticks and %0d done requests over %0d register settings",
               ticks_accepted, dones_accepted, settings_used);
      $display("summary: %0d responses checked, %0d overdue, %0d past half the timeout",
               reports_checked, overdue_reports, half_reports);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/mchw_pkg.sv
rtl/mchw_front.sv
rtl/mchw_queue.sv
rtl/mchw_back.sv
rtl/multi_channel_hang_watchdog_unit.sv
test/tb_multi_channel_hang_watchdog_unit.sv
